// ===== rtl/asr_pkg.sv =====
// Shared types and constants for the ASR envelope generator.
// No dependencies.
`timescale 1ns / 1ps

package asr_pkg;

  localparam int DURATION_BITS_DEF = 24;
  localparam int LEVEL_BITS_DEF    = 16;
  localparam int ELAPSED_BITS      = 32;

  // Segment of the envelope that a frame falls in
  typedef enum logic [1:0] {
    KIND_ATTACK  = 2'd0,
    KIND_FULL    = 2'd1,
    KIND_RELEASE = 2'd2,
    KIND_ZERO    = 2'd3
  } env_kind_t;

  typedef struct packed {
    logic      done;
    env_kind_t kind;
  } cls_res_t;

endpackage

// ===== rtl/asr_if.sv =====
// Valid/ready channel interfaces for frame input and level output.
// Depends on asr_pkg.
`timescale 1ns / 1ps

interface asr_in_if #(
  parameter int DURATION_BITS = asr_pkg::DURATION_BITS_DEF
);
  logic                     valid;
  logic                     ready;
  logic                     trigger;
  logic [DURATION_BITS-1:0] attack_len;
  logic [DURATION_BITS-1:0] sustain_len;
  logic [DURATION_BITS-1:0] release_len;

  modport source (
    output valid, trigger, attack_len, sustain_len, release_len,
    input  ready
  );
  modport sink (
    input  valid, trigger, attack_len, sustain_len, release_len,
    output ready
  );
endinterface

interface asr_out_if #(
  parameter int LEVEL_BITS = asr_pkg::LEVEL_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [LEVEL_BITS-1:0] level;

  modport source (
    output valid, level,
    input  ready
  );
  modport sink (
    input  valid, level,
    output ready
  );
endinterface

// ===== rtl/asr_cls.sv =====
// Segment classifier: registered sequence of compares that picks the
// envelope segment and the division operands. Depends on asr_pkg.
`timescale 1ns / 1ps

module asr_cls #(
  parameter int DURATION_BITS = asr_pkg::DURATION_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [asr_pkg::ELAPSED_BITS-1:0] p,
  input  logic [DURATION_BITS-1:0]         a,
  input  logic [DURATION_BITS-1:0]         s,
  input  logic [DURATION_BITS-1:0]         r,
  output asr_pkg::cls_res_t                res,
  output logic [DURATION_BITS-1:0]         d,
  output logic [DURATION_BITS-1:0]         den
);
  import asr_pkg::*;

  localparam int EB = ELAPSED_BITS;

  logic [EB-1:0] a_ext, s_ext, r_ext;
  logic [EB-1:0] sum_as_r, sum_asr_r, diff_w;
  logic [DURATION_BITS-1:0] diff_r, d_r, den_r;
  logic lt_a_r, le_as_r;
  logic st1_r, st2_r, done_r;
  env_kind_t kind_r;

  assign a_ext  = {{(EB-DURATION_BITS){1'b0}}, a};
  assign s_ext  = {{(EB-DURATION_BITS){1'b0}}, s};
  assign r_ext  = {{(EB-DURATION_BITS){1'b0}}, r};
  assign diff_w = p - sum_as_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st1_r  <= 1'b0;
      st2_r  <= 1'b0;
      done_r <= 1'b0;
      kind_r <= KIND_ZERO;
    end else begin
      st1_r  <= start;
      st2_r  <= st1_r;
      done_r <= st2_r;
      if (st2_r) begin
        if (lt_a_r) begin
          kind_r <= KIND_ATTACK;
        end else if (le_as_r) begin
          kind_r <= KIND_FULL;
        end else if (p < sum_asr_r) begin
          kind_r <= KIND_RELEASE;
        end else begin
          kind_r <= KIND_ZERO;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sum_as_r <= a_ext + s_ext;
      lt_a_r   <= p < a_ext;
    end
    if (st1_r) begin
      sum_asr_r <= sum_as_r + r_ext;
      le_as_r   <= p <= sum_as_r;
      diff_r    <= diff_w[DURATION_BITS-1:0];
    end
    if (st2_r) begin
      d_r   <= lt_a_r ? p[DURATION_BITS-1:0] : diff_r;
      den_r <= lt_a_r ? a : r;
    end
  end

  assign res.done = done_r;
  assign res.kind = kind_r;
  assign d        = d_r;
  assign den      = den_r;

endmodule

// ===== rtl/asr_div.sv =====
// Bit-serial restoring divider: floor(num * FULL / den), one quotient bit
// per cycle. Requires num < den. Depends on asr_pkg.
`timescale 1ns / 1ps

module asr_div #(
  parameter int DURATION_BITS = asr_pkg::DURATION_BITS_DEF,
  parameter int LEVEL_BITS    = asr_pkg::LEVEL_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [DURATION_BITS-1:0] num,
  input  logic [DURATION_BITS-1:0] den,
  output logic                     done,
  output logic [LEVEL_BITS-1:0]    quot
);
  import asr_pkg::*;

  localparam int NB = DURATION_BITS + LEVEL_BITS;
  localparam int CB = $clog2(LEVEL_BITS + 1);

  logic [NB-1:0]            prod;
  logic [DURATION_BITS-1:0] den_r, rem_r;
  logic [LEVEL_BITS-1:0]    nlo_r, q_r;
  logic [CB-1:0]            cnt_r;
  logic                     busy_r, done_r;
  logic [DURATION_BITS:0]   trial, diff;
  logic                     ge;

  // num * (2^L - 1); top part is below den since num < den
  assign prod  = {num, {LEVEL_BITS{1'b0}}} - {{LEVEL_BITS{1'b0}}, num};
  assign trial = {rem_r, nlo_r[LEVEL_BITS-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CB'(LEVEL_BITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CB'(1);
        if (cnt_r == CB'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      rem_r <= prod[NB-1:LEVEL_BITS];
      nlo_r <= prod[LEVEL_BITS-1:0];
    end else if (busy_r) begin
      rem_r <= ge ? diff[DURATION_BITS-1:0] : trial[DURATION_BITS-1:0];
      nlo_r <= {nlo_r[LEVEL_BITS-2:0], 1'b0};
      q_r   <= {q_r[LEVEL_BITS-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// ===== rtl/asr_envelope_generator.sv =====
// Channel   Dir  Beat contents
// in_ch     in   trigger, attack_len, sustain_len, release_len
// out_ch    out  level
//
// One frame at a time. Attack and release frames go from the classifier
// to the bit-serial divider (one quotient bit per cycle); flat frames skip
// the divider and go straight to the output stage.
// A finished level sits in the output register; the next frame is taken
// while it waits. Reset (synchronous) clears the sample counter.
// Depends on asr_pkg, asr_if, asr_cls, asr_div.
`timescale 1ns / 1ps

module asr_envelope_generator #(
  parameter int DURATION_BITS = asr_pkg::DURATION_BITS_DEF,
  parameter int LEVEL_BITS    = asr_pkg::LEVEL_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  asr_in_if.sink     in_ch,
  asr_out_if.source  out_ch
);
  import asr_pkg::*;

  localparam int EB = ELAPSED_BITS;
  localparam logic [LEVEL_BITS-1:0] LEVEL_FULL = {LEVEL_BITS{1'b1}};
  localparam logic [EB-1:0]         ELAPSED_MAX = {EB{1'b1}};

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CLS  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  state_t state_r;
  logic [EB-1:0] elapsed_r, p_r, p_nxt;
  logic [DURATION_BITS-1:0] a_r, s_r, r_r;
  logic [LEVEL_BITS-1:0] res_r, level_r;
  logic out_valid_r, cls_start_r;
  logic in_fire, out_free, ramp;
  cls_res_t cls_res;
  logic [DURATION_BITS-1:0] cls_d, cls_den;
  logic div_start, div_done;
  logic [LEVEL_BITS-1:0] quot;

  assign in_fire   = in_ch.valid && (state_r == ST_IDLE);
  assign out_free  = !out_valid_r || out_ch.ready;
  assign p_nxt     = in_ch.trigger ? '0 : elapsed_r;
  assign ramp      = (cls_res.kind == KIND_ATTACK) || (cls_res.kind == KIND_RELEASE);
  assign div_start = (state_r == ST_CLS) && cls_res.done && ramp;

  asr_cls #(
    .DURATION_BITS(DURATION_BITS)
  ) u_cls (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cls_start_r),
    .p     (p_r),
    .a     (a_r),
    .s     (s_r),
    .r     (r_r),
    .res   (cls_res),
    .d     (cls_d),
    .den   (cls_den)
  );

  asr_div #(
    .DURATION_BITS(DURATION_BITS),
    .LEVEL_BITS   (LEVEL_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (cls_d),
    .den   (cls_den),
    .done  (div_done),
    .quot  (quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      elapsed_r   <= '0;
      cls_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cls_start_r <= in_fire;
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            elapsed_r <= (p_nxt == ELAPSED_MAX) ? p_nxt : p_nxt + EB'(1);
            state_r   <= ST_CLS;
          end
        end
        ST_CLS: begin
          if (cls_res.done) begin
            state_r <= ramp ? ST_DIV : ST_FIN;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      p_r <= p_nxt;
      a_r <= in_ch.attack_len;
      s_r <= in_ch.sustain_len;
      r_r <= in_ch.release_len;
    end
    if (state_r == ST_CLS && cls_res.done) begin
      res_r <= (cls_res.kind == KIND_FULL) ? LEVEL_FULL : '0;
    end
    if (state_r == ST_DIV && div_done) begin
      res_r <= (cls_res.kind == KIND_ATTACK) ? quot : LEVEL_FULL - quot;
    end
    if (state_r == ST_FIN && out_free) begin
      level_r <= res_r;
    end
  end

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.level = level_r;

endmodule

// ===== rtl/asr_checker.sv =====
// Port-level checks for the ASR envelope generator, bound to the top level.
// Depends on asr_pkg and asr_envelope_generator.
`timescale 1ns / 1ps

module asr_checker #(
  parameter int LEVEL_BITS = asr_pkg::LEVEL_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [LEVEL_BITS-1:0] out_level
);
  import asr_pkg::*;

  logic [1:0] pend_r;
  logic in_beat, out_beat;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + {1'b0, in_beat} - {1'b0, out_beat};
    end
  end

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out valid after reset");

  a_one_frame: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> !in_ready)
    else $error("input taken while a frame is in work");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_level))
    else $error("stalled output beat changed");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("output beat without input beat");

  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("too many frames in flight");

endmodule

bind asr_envelope_generator asr_checker #(
  .LEVEL_BITS(LEVEL_BITS)
) u_asr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_level (out_ch.level)
);
